### sv/asr_pkg.sv
// Shared types and constants for the asymmetric setpoint ramp.
// Used by asr_core and asymmetric_setpoint_ramp; depends on nothing else.
package asr_pkg;

    // Step registers are unsigned Q15.16 and 31 bits wide.
    localparam int STEP_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INCREASE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECREASE_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_FIRST_MODE = 2'd2;

    typedef struct packed {
        logic [STEP_W-1:0] increase_step;
        logic [STEP_W-1:0] decrease_step;
        logic              real_first_mode;
    } t_cfg;

endpackage

### sv/asr_core.sv
// Combinational ramp step: base selection, step choice, snap and saturation.
// Depends on asr_pkg for the configuration struct and step width.
module asr_core
    import asr_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  t_cfg                   i_cfg,
    input  logic [DATA_WIDTH-1:0]  i_target,
    input  logic [DATA_WIDTH-1:0]  i_measured,
    input  logic [DATA_WIDTH-1:0]  i_plan,
    output logic [DATA_WIDTH-1:0]  o_result
);

    // Working width holds the exact distance, the step and a signed sum with margin.
    localparam int CW = (((DATA_WIDTH + 1) > STEP_W) ? (DATA_WIDTH + 1) : STEP_W) + 2;

    localparam logic signed [CW-1:0] VAL_MAX =
        {{(CW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [CW-1:0] VAL_MIN =
        {{(CW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    logic signed [DATA_WIDTH-1:0] t, m, p, base;
    logic                         between, up, shrink, snap;
    logic signed [DATA_WIDTH:0]   diff;
    logic [CW-1:0]                dist_x, step_x;
    logic [STEP_W-1:0]            step;
    logic signed [CW-1:0]         base_x, sum;
    logic signed [DATA_WIDTH-1:0] sat;

    always_comb begin
        t = i_target;
        m = i_measured;
        p = i_plan;

        between = i_cfg.real_first_mode &&
                  (((t >= m) && (m >= p)) || ((t <= m) && (m <= p)));
        base = between ? m : p;

        up = t > p;
        if (up) begin
            diff = {t[DATA_WIDTH-1], t} - {p[DATA_WIDTH-1], p};
        end else begin
            diff = {p[DATA_WIDTH-1], p} - {t[DATA_WIDTH-1], t};
        end
        dist_x = {{(CW-DATA_WIDTH-1){1'b0}}, diff};

        // Moving toward zero from a nonzero plan shrinks the magnitude.
        shrink = ((p > 0) && !up) || ((p < 0) && up);
        step   = shrink ? i_cfg.decrease_step : i_cfg.increase_step;
        step_x = {{(CW-STEP_W){1'b0}}, step};
        snap   = dist_x <= step_x;

        base_x = {{(CW-DATA_WIDTH){base[DATA_WIDTH-1]}}, base};
        sum    = up ? (base_x + $signed(step_x)) : (base_x - $signed(step_x));
        if (sum > VAL_MAX) begin
            sat = VAL_MAX[DATA_WIDTH-1:0];
        end else if (sum < VAL_MIN) begin
            sat = VAL_MIN[DATA_WIDTH-1:0];
        end else begin
            sat = sum[DATA_WIDTH-1:0];
        end

        if (t == p) begin
            o_result = base;
        end else if (snap) begin
            o_result = t;
        end else begin
            o_result = sat;
        end
    end

endmodule

### sv/asymmetric_setpoint_ramp.sv
// Top level of the asymmetric setpoint ramp: stream ports, configuration
// registers, input register, plan register and result register.
// Depends on asr_pkg and asr_core.

// The block takes one request per control tick carrying a target and a measured
// value, both signed Q16.16, and returns one request with the new planned
// setpoint. It accepts a request whenever the input register is empty or its
// item moves on. A request passes two registers (input register, then result
// register) on its way to the master side; sustained throughput is one request
// per cycle while the master side does not stall. That rate is set by the plan
// feedback loop: the new plan is computed combinationally from the input register
// and the plan register and written back together with the result. Configuration
// writes are always accepted and should only be issued while the block is idle.
module asymmetric_setpoint_ramp
    import asr_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave side. tdata: target_value [DATA_WIDTH-1:0], measured_value above it,
    // zero padding to whole bytes.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // Master side. tdata: ramp_output [DATA_WIDTH-1:0], zero padding to whole bytes.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0]           i_cfg_data
);

    localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

    t_cfg                  r_cfg;
    logic                  r_in_valid;
    logic [DATA_WIDTH-1:0] r_target, r_measured;
    logic [DATA_WIDTH-1:0] r_plan;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_data;
    logic [DATA_WIDTH-1:0] n_result;
    logic                  fire;

    // Configuration registers; an index beyond the list is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INCREASE_STEP:   r_cfg.increase_step   <= i_cfg_data[STEP_W-1:0];
                CFG_DECREASE_STEP:   r_cfg.decrease_step   <= i_cfg_data[STEP_W-1:0];
                CFG_REAL_FIRST_MODE: r_cfg.real_first_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The item in the input register is processed when the result register is
    // free or being emptied in this cycle. The input register refills whenever
    // it is empty or its item moves on, so a stalled output stops new requests
    // only once the input register is full as well.
    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_target   <= i_s_tdata[DATA_WIDTH-1:0];
            r_measured <= i_s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        end
    end

    asr_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_cfg      (r_cfg),
        .i_target   (r_target),
        .i_measured (r_measured),
        .i_plan     (r_plan),
        .o_result   (n_result)
    );

    // The plan and the result register are written together, so the next item
    // in the input register already sees the updated plan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_plan <= n_result;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_W-DATA_WIDTH){1'b0}}, r_out_data};

    // A processed item always shows up as a valid result in the next cycle.
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_m_tvalid)
        else $error("processed item did not produce a result");

    // The plan register always follows the result just produced.
    a_plan_tracks_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_plan == r_out_data))
        else $error("plan register differs from the delivered result");

    // Input back-pressure only when both registers are full and the output stalls.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled without a full pipeline");

    // Reset empties the result register.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule
